FILE: hw/rtl/bfer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfer_pkg
// Shared types and codes of the byte FIFO endian reader: action and status
// codes and the fixed field widths of the request and response channels.
// ----------------------------------------------------------------------------
package bfer_pkg;

   localparam int ACTION_W = 3;
   localparam int BYTE_W   = 8;
   localparam int SIZE_W   = 4;
   localparam int DROP_W   = 13;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int MAX_READ = 8;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SIZE_W-1:0]   size_type;
   typedef logic [VALUE_W-1:0]  value_type;

   localparam action_type ACT_PUSH      = 3'd0;
   localparam action_type ACT_READ      = 3'd1;
   localparam action_type ACT_DROP_HEAD = 3'd2;
   localparam action_type ACT_DROP_TAIL = 3'd3;
   localparam action_type ACT_CLEAR     = 3'd4;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_UNDER = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

endpackage

FILE: hw/rtl/bfer_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfer_req_if
// Request channel: one FIFO action per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfer_req_if
   import bfer_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   push_byte;
   logic [SIZE_W-1:0]   read_size;
   logic                big_endian;
   logic [DROP_W-1:0]   drop_count;

   modport source (
      output valid, action, push_byte, read_size, big_endian, drop_count,
      input  ready
   );
   modport sink (
      input  valid, action, push_byte, read_size, big_endian, drop_count,
      output ready
   );
endinterface

FILE: hw/rtl/bfer_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfer_rsp_if
// Response channel: read value, status and fill level, valid/ready handshake.
// FILL_W must equal $clog2(DEPTH + 1) of the reader it is attached to.
// ----------------------------------------------------------------------------
interface bfer_rsp_if
   import bfer_pkg::*;
#(
   parameter int FILL_W = 13
);
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic [STATUS_W-1:0] status;
   logic [FILL_W-1:0]   fill_level;

   modport source (
      output valid, read_value, status, fill_level,
      input  ready
   );
   modport sink (
      input  valid, read_value, status, fill_level,
      output ready
   );
endinterface

FILE: hw/rtl/byte_fifo_endian_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_fifo_endian_reader
// Byte FIFO of DEPTH entries with integer reads of 1 to 8 bytes from the head.
// ----------------------------------------------------------------------------
// One request is handled at a time. Push, drop and clear go from IDLE to
// DONE and back to IDLE; a read of n bytes passes through READ, paced by
// the single read port of the byte memory, which delivers one byte per
// cycle from its registered read port. A response waiting in
// the output register does not hold off the next request; only its own
// result waits for the register to drain. No clearing pass is needed after
// reset: bytes are only read after a push wrote them.
// ----------------------------------------------------------------------------
module byte_fifo_endian_reader
   import bfer_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic       clock,
   input  logic       reset,
   bfer_req_if.sink   req_chan,
   bfer_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > DROP_W) ? CW : DROP_W) + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   size_type          size_ff, size_in;
   size_type          issued_ff, issued_in;
   size_type          recv_ff, recv_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              big_ff, big_in;
   value_type         val_ff, val_in;
   status_type        res_status_ff, res_status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CW-1:0]     rsp_fill_ff, rsp_fill_in;

   logic              accept;
   logic              rd_en;
   logic              wr_en;
   logic [BYTE_W-1:0] rd_data;
   logic              out_free;
   size_type          sat_size;
   logic [XW-1:0]     held_x;
   logic [XW-1:0]     drop_x;
   logic [XW-1:0]     head_sum;
   logic [XW-1:0]     tail_x;
   logic [XW-1:0]     tail_back;
   logic [XW-1:0]     size_x;
   logic [XW-1:0]     read_sum;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign sat_size  = (req_chan.read_size > size_type'(MAX_READ)) ? size_type'(MAX_READ)
                                                                 : req_chan.read_size;
   assign held_x    = XW'(count_ff);
   assign drop_x    = XW'(req_chan.drop_count);
   assign size_x    = XW'(sat_size);
   assign head_sum  = XW'(head_ff) + drop_x;
   assign read_sum  = XW'(head_ff) + size_x;
   assign tail_x    = XW'(tail_ff);
   assign tail_back = (tail_x >= drop_x) ? (tail_x - drop_x)
                                         : (tail_x + XW'(DEPTH) - drop_x);

   assign wr_en = accept && (req_chan.action == ACT_PUSH) && (count_ff != CW'(DEPTH));
   assign rd_en = (state_ff == ST_READ) && (issued_ff < size_ff);

   bfer_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_chan.push_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      size_in       = size_ff;
      issued_in     = issued_ff;
      recv_in       = recv_ff;
      rd_valid_in   = rd_en;
      big_in        = big_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in        = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
               case (req_chan.action)
                  ACT_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        tail_in  = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_READ: begin
                     if (size_x > held_x) begin
                        res_status_in = STATUS_UNDER;
                     end else if (sat_size != '0) begin
                        rd_ptr_in = head_ff;
                        size_in   = sat_size;
                        issued_in = '0;
                        recv_in   = '0;
                        big_in    = req_chan.big_endian;
                        head_in   = (read_sum >= XW'(DEPTH)) ? AW'(read_sum - XW'(DEPTH))
                                                             : AW'(read_sum);
                        count_in  = CW'(held_x - size_x);
                        state_in  = ST_READ;
                     end
                  end
                  ACT_DROP_HEAD: begin
                     if (drop_x > held_x) begin
                        res_status_in = STATUS_UNDER;
                     end else begin
                        head_in  = (head_sum >= XW'(DEPTH)) ? AW'(head_sum - XW'(DEPTH))
                                                            : AW'(head_sum);
                        count_in = CW'(held_x - drop_x);
                     end
                  end
                  ACT_DROP_TAIL: begin
                     if (drop_x > held_x) begin
                        res_status_in = STATUS_UNDER;
                     end else begin
                        tail_in  = AW'(tail_back);
                        count_in = CW'(held_x - drop_x);
                     end
                  end
                  ACT_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (rd_en) begin
               issued_in = issued_ff + 1'b1;
               rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (big_ff) begin
                  val_in = {val_ff[VALUE_W-BYTE_W-1:0], rd_data};
               end else begin
                  val_in = val_ff;
                  val_in[recv_ff[2:0]*BYTE_W +: BYTE_W] = rd_data;
               end
               recv_in = recv_ff + 1'b1;
               if (recv_in == size_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_status_in = res_status_ff;
               rsp_fill_in   = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issued_ff    <= '0;
         recv_ff      <= '0;
         size_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         issued_ff    <= issued_in;
         recv_ff      <= recv_in;
         size_ff      <= size_in;
      end
      rd_ptr_ff     <= rd_ptr_in;
      big_ff        <= big_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.fill_level = rsp_fill_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      XW'(count_ff) <= XW'(DEPTH))
      else $error("fill count above capacity");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == CW'(DEPTH)) && (tail_ff == head_ff)) ||
      ((count_ff != CW'(DEPTH)) && (tail_ff >= head_ff) &&
         (XW'(tail_ff) - XW'(head_ff) == XW'(count_ff))) ||
      ((count_ff != CW'(DEPTH)) && (tail_ff < head_ff) &&
         (XW'(tail_ff) + XW'(DEPTH) - XW'(head_ff) == XW'(count_ff))))
      else $error("head, tail and fill count disagree");

   a_recv_behind_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ((recv_ff <= issued_ff) && (issued_ff <= size_ff)))
      else $error("read byte received before it was issued");

   a_fail_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |-> (rsp_value_ff == '0))
      else $error("nonzero value on a failed request");

   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !wr_en)
      else $error("byte store written during a read");
`endif

endmodule

FILE: hw/rtl/bfer_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfer_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bfer_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
